// ===== hdl/acd_pkg.sv =====
// Shared constants, types and lookup functions for the activation code decoder.
`timescale 1ns / 1ps

package acd_pkg;

  localparam int unsigned NumDigits = 14;
  localparam int unsigned RotDigits = 12;
  localparam int unsigned SeqCodes  = 100;

  localparam int unsigned CodeW = 4 * NumDigits;
  localparam int unsigned SeqW  = 7;
  localparam int unsigned IdW   = 30;
  localparam int unsigned DaysW = 10;
  localparam int unsigned HiW   = 17;
  localparam int unsigned LoW   = 14;

  // One decoded digit from a lane.
  typedef struct packed {
    logic [3:0] value;
    logic       bad;
  } acd_digit_t;

  // Partial results of the merge stage.
  typedef struct packed {
    logic [SeqW-1:0]  seqn;
    logic [HiW-1:0]   id_hi;
    logic [LoW-1:0]   id_lo;
    logic [DaysW-1:0] days;
  } acd_part_t;

  // Sequence code to sequence number.
  localparam logic [SeqW-1:0] InvPerm [SeqCodes] = '{
    7'd64, 7'd30, 7'd31, 7'd36, 7'd82, 7'd34, 7'd49, 7'd95, 7'd42, 7'd26,
    7'd50, 7'd57, 7'd66, 7'd20, 7'd65, 7'd7,  7'd41, 7'd63, 7'd58, 7'd27,
    7'd23, 7'd38, 7'd94, 7'd99, 7'd44, 7'd37, 7'd11, 7'd24, 7'd61, 7'd92,
    7'd47, 7'd39, 7'd72, 7'd48, 7'd77, 7'd0,  7'd81, 7'd83, 7'd29, 7'd74,
    7'd60, 7'd84, 7'd59, 7'd13, 7'd51, 7'd78, 7'd25, 7'd68, 7'd97, 7'd56,
    7'd12, 7'd73, 7'd18, 7'd54, 7'd79, 7'd15, 7'd22, 7'd35, 7'd14, 7'd98,
    7'd89, 7'd40, 7'd76, 7'd5,  7'd33, 7'd96, 7'd85, 7'd21, 7'd70, 7'd2,
    7'd87, 7'd17, 7'd52, 7'd28, 7'd6,  7'd43, 7'd62, 7'd32, 7'd46, 7'd90,
    7'd67, 7'd75, 7'd10, 7'd53, 7'd8,  7'd80, 7'd1,  7'd69, 7'd9,  7'd88,
    7'd93, 7'd86, 7'd45, 7'd3,  7'd91, 7'd55, 7'd19, 7'd16, 7'd71, 7'd4
  };

  // Undo the digit substitution; nibbles above nine give zero.
  function automatic logic [3:0] inv_subst(logic [3:0] nib);
    logic [3:0] res;
    unique case (nib)
      4'd0:    res = 4'd5;
      4'd1:    res = 4'd0;
      4'd2:    res = 4'd2;
      4'd3:    res = 4'd9;
      4'd4:    res = 4'd4;
      4'd5:    res = 4'd8;
      4'd6:    res = 4'd3;
      4'd7:    res = 4'd1;
      4'd8:    res = 4'd7;
      4'd9:    res = 4'd6;
      default: res = 4'd0;
    endcase
    return res;
  endfunction

  // Tens digit times ten, modulo twelve.
  function automatic logic [3:0] tens_mod12(logic [3:0] d);
    logic [3:0] res;
    unique case (d) inside
      4'd0, 4'd6: res = 4'd0;
      4'd1, 4'd7: res = 4'd10;
      4'd2, 4'd8: res = 4'd8;
      4'd3, 4'd9: res = 4'd6;
      4'd4:       res = 4'd4;
      4'd5:       res = 4'd2;
      default:    res = 4'd0;
    endcase
    return res;
  endfunction

endpackage

// ===== hdl/acd_lane.sv =====
// One digit lane: range check and inverse substitution of a BCD nibble.
`timescale 1ns / 1ps

module acd_lane
  import acd_pkg::*;
(
  input  logic [3:0] nibble_i,
  output acd_digit_t digit_o
);

  always_comb begin
    digit_o.bad   = (nibble_i > 4'd9);
    digit_o.value = inv_subst(nibble_i);
  end

endmodule

// ===== hdl/acd_merge.sv =====
// Merge stage: sequence code, rotation, sequence lookup and partial BCD sums.
`timescale 1ns / 1ps

module acd_merge
  import acd_pkg::*;
(
  input  logic [NumDigits-1:0][3:0] digits_i,
  output acd_part_t                 part_o
);

  logic [SeqW-1:0]         seq_code;
  logic [4:0]              mod_sum;
  logic [3:0]              shift;
  logic [5:0]              shl_amt;
  logic [5:0]              shr_amt;
  logic [4*RotDigits-1:0]  head;
  logic [4*RotDigits-1:0]  rotated;
  logic [RotDigits-1:0][HiW-1:0] r;

  always_comb begin
    seq_code = SeqW'(digits_i[12]) * SeqW'(10) + SeqW'(digits_i[13]);
    mod_sum  = 5'(tens_mod12(digits_i[12])) + 5'(digits_i[13]);
    shift    = (mod_sum >= 5'd12) ? 4'(mod_sum - 5'd12) : mod_sum[3:0];
  end

  // Digit 0 sits at the top of the head word; rotate left by whole digits.
  always_comb begin
    for (int i = 0; i < RotDigits; i++) begin
      head[4*(RotDigits-1-i) +: 4] = digits_i[i];
    end
    shl_amt = {shift, 2'b00};
    shr_amt = 6'(4 * RotDigits) - shl_amt;
    rotated = (head << shl_amt) | (head >> shr_amt);
    for (int i = 0; i < RotDigits; i++) begin
      r[i] = HiW'(rotated[4*(RotDigits-1-i) +: 4]);
    end
  end

  always_comb begin
    part_o.seqn  = InvPerm[seq_code];
    part_o.id_hi = r[0] * HiW'(10000) + r[1] * HiW'(1000) + r[2] * HiW'(100)
                 + r[3] * HiW'(10) + r[4];
    part_o.id_lo = LoW'(r[5] * HiW'(1000) + r[6] * HiW'(100) + r[7] * HiW'(10)
                 + r[8]);
    part_o.days  = DaysW'(r[9] * HiW'(100) + r[10] * HiW'(10) + r[11]);
  end

endmodule

// ===== hdl/activation_code_decoder.sv =====
// Top level of the activation code decoder: digit lanes, merge and output pipeline.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+-------------------------------------
//   code in  | input     | in_valid_i/in_ready_o | code_digits_i
//   result   | output    | out_valid_o/out_ready_i | sequence_number_o, device_id_o,
//            |           |                       | day_count_o, bad_digit_o
//
// One word is taken per cycle when not stalled; each result passes three registers
// (lanes register, merge register, final id combine into the output register).
// Reset empties all three stages; no table needs clearing.
// A stall on the result side holds the pipeline; a stage still takes a new word
// whenever the stage after it is empty or moving on in the same cycle.
`timescale 1ns / 1ps

module activation_code_decoder
  import acd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [CodeW-1:0] code_digits_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [SeqW-1:0]  sequence_number_o,
  output logic [IdW-1:0]   device_id_o,
  output logic [DaysW-1:0] day_count_o,
  output logic             bad_digit_o
);

  acd_digit_t                lane_digit [NumDigits];
  logic [NumDigits-1:0][3:0] lane_value;
  logic [NumDigits-1:0]      lane_bad;

  logic                      s1_valid_q;
  logic [NumDigits-1:0][3:0] s1_digits_q;
  logic                      s1_bad_q;
  logic                      s2_valid_q;
  acd_part_t                 s2_part_q;
  logic                      s2_bad_q;
  acd_part_t                 merge_part;
  logic                      s1_ready;
  logic                      s2_ready;
  logic                      s3_ready;
  logic [IdW-1:0]            id_d;

  for (genvar g = 0; g < NumDigits; g++) begin : g_lane
    acd_lane u_lane (
      .nibble_i (code_digits_i[4*(NumDigits-1-g) +: 4]),
      .digit_o  (lane_digit[g])
    );
    assign lane_value[g] = lane_digit[g].value;
    assign lane_bad[g]   = lane_digit[g].bad;
  end

  acd_merge u_merge (
    .digits_i (s1_digits_q),
    .part_o   (merge_part)
  );

  assign s3_ready   = !out_valid_o || out_ready_i;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  assign id_d = IdW'(s2_part_q.id_hi) * IdW'(10000) + IdW'(s2_part_q.id_lo);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q <= in_valid_i;
      if (s2_ready) s2_valid_q <= s1_valid_q;
      if (s3_ready) out_valid_o <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_digits_q <= lane_value;
      s1_bad_q    <= |lane_bad;
    end
    if (s2_ready && s1_valid_q) begin
      s2_part_q <= merge_part;
      s2_bad_q  <= s1_bad_q;
    end
    // Force the numeric fields to zero on a bad digit.
    if (s3_ready && s2_valid_q) begin
      bad_digit_o       <= s2_bad_q;
      sequence_number_o <= s2_bad_q ? '0 : s2_part_q.seqn;
      device_id_o       <= s2_bad_q ? '0 : id_d;
      day_count_o       <= s2_bad_q ? '0 : s2_part_q.days;
    end
  end

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_digit_o |->
      sequence_number_o == '0 && device_id_o == '0 && day_count_o == '0)
    else $error("bad digit result carries non-zero fields");

  a_good_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !bad_digit_o |->
      sequence_number_o < SeqW'(SeqCodes) && device_id_o <= IdW'(999999999)
      && day_count_o <= DaysW'(999))
    else $error("decoded field out of range");

  a_accept_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> s1_valid_q)
    else $error("accepted word lost at first stage");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && s2_valid_q && out_valid_o && !out_ready_i)
    else $error("input stalled with a free stage");

endmodule
